>>> sv/sfd_pkg.sv
package sfd_pkg;

    localparam int PAYLOAD_BYTES = 18;
    localparam int HDR_LEN       = 6;
    localparam int NUM_WORDS     = 9;

    localparam int POS_CRC_LO = HDR_LEN + PAYLOAD_BYTES;
    localparam int POS_CRC_HI = POS_CRC_LO + 1;
    localparam int POS_TRL0   = POS_CRC_LO + 2;
    localparam int POS_TRL1   = POS_CRC_LO + 3;
    localparam int POS_TRL2   = POS_CRC_LO + 4;
    localparam int POS_W      = $clog2(POS_TRL2 + 1);

    // words that actually hold payload bytes
    localparam int STORED_WORDS = ((PAYLOAD_BYTES + 1) / 2 < NUM_WORDS) ?
                                  (PAYLOAD_BYTES + 1) / 2 : NUM_WORDS;

    // two banks of words: one filling, one waiting to be drained
    localparam int RAM_DEPTH = 2 * NUM_WORDS;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int WORD_W    = $clog2(NUM_WORDS);

    localparam logic [15:0] CRC_SEED_RST = 16'h00FF;

    localparam logic [7:0] HDR_0   = 8'h3E;  // '>'
    localparam logic [7:0] HDR_1   = 8'h2A;  // '*'
    localparam logic [7:0] HDR_2   = 8'h3E;  // '>'
    localparam logic [7:0] HDR_3   = 8'h12;
    localparam logic [7:0] HDR_4   = 8'h00;
    localparam logic [7:0] HDR_5   = 8'h63;  // 'c'
    localparam logic [7:0] TRL_LT  = 8'h3C;  // '<'
    localparam logic [7:0] TRL_HSH = 8'h23;  // '#'

    typedef struct packed {
        logic              we;
        logic              bank;
        logic [RAM_AW-1:0] addr;
        logic [15:0]       data;
    } sfd_wr_t;

    typedef struct packed {
        logic valid;
        logic bank;
        logic ok;
    } sfd_done_t;

    typedef struct packed {
        logic pend;
        logic bank;
    } sfd_stat_t;

    function automatic logic [7:0] hdr_byte(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = HDR_0;
            3'd1:    r = HDR_1;
            3'd2:    r = HDR_2;
            3'd3:    r = HDR_3;
            3'd4:    r = HDR_4;
            3'd5:    r = HDR_5;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // reflected CRC-CCITT (0x8408), one byte
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [7:0] d;
        d = b ^ c[7:0];
        d = d ^ (d << 4);
        return {d, c[15:8]} ^ (16'(d) >> 4) ^ (16'(d) << 3);
    endfunction

    function automatic logic [POS_W-1:0] restart_pos(input logic [7:0] b);
        return (b == HDR_0) ? POS_W'(1) : POS_W'(0);
    endfunction

    function automatic logic [RAM_AW-1:0] ram_addr(input logic bank,
                                                    input logic [RAM_AW-1:0] word);
        return bank ? RAM_AW'(NUM_WORDS) + word : word;
    endfunction

endpackage

>>> sv/sonar_frame_deframer_crc16_core.sv
// A result beat shows on out_valid after the final trailer byte sets the pending flag and the
// drain passes S_IDLE, S_READ and S_WAIT. Throughput: one byte per cycle unless in_stall
// holds; the parser updates position and CRC per taken byte. The final trailer byte stalls
// only while the previous frame's words still wait in the two-bank word RAM to be drained.
// Reset (rst_n, async low): hunt state, CRCs and handshake flags clear, crc_seed = 0x00FF;
// the word RAM is not cleared, every word is written before it is read.
module sonar_frame_deframer_crc16_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] range_1,
    output logic [15:0] range_2,
    output logic [15:0] range_3,
    output logic [15:0] range_4,
    output logic [15:0] range_5,
    output logic [15:0] range_6,
    output logic [15:0] range_7,
    output logic [15:0] range_8,
    output logic [15:0] range_9,
    output logic        crc_ok
);

    // parser -> RAM: payload words, bank toggles per completed frame
    sfd_pkg::sfd_wr_t           wr;
    // parser -> drain: frame complete beat with bank and CRC verdict
    sfd_pkg::sfd_done_t         done;
    // drain -> parser: a frame still waits in RAM
    sfd_pkg::sfd_stat_t         stat;
    logic [sfd_pkg::RAM_AW-1:0] raddr;
    logic [15:0]                rdata;
    logic [15:0]                words [sfd_pkg::NUM_WORDS];

    sfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .wr        (wr),
        .done      (done)
    );

    // bank = frame slot; writer and drain never share a bank (parser interlock)
    sfd_ram #(
        .WIDTH (16),
        .DEPTH (sfd_pkg::RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (raddr),
        .rdata (rdata)
    );

    sfd_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .done      (done),
        .stat      (stat),
        .raddr     (raddr),
        .rdata     (rdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .words     (words),
        .crc_ok    (crc_ok)
    );

    assign range_1 = words[0];
    assign range_2 = words[1];
    assign range_3 = words[2];
    assign range_4 = words[3];
    assign range_5 = words[4];
    assign range_6 = words[5];
    assign range_7 = words[6];
    assign range_8 = words[7];
    assign range_9 = words[8];

`ifndef SYNTHESIS
    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.we && stat.pend) |-> (wr.bank != stat.bank))
        else $error("payload write into bank awaiting drain");
`endif

endmodule

>>> sv/sfd_ram.sv
module sfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 18
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sfd_parser.sv
module sfd_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               cfg_wen,
    input  logic [15:0]        cfg_wdata,
    input  sfd_pkg::sfd_stat_t stat,
    output sfd_pkg::sfd_wr_t   wr,
    output sfd_pkg::sfd_done_t done
);

    logic [sfd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0]               crc_reg, crc_next;
    logic [15:0]               rcrc_reg, rcrc_next;
    logic [15:0]               seed_reg;
    logic [7:0]                lo_reg, lo_next;
    logic                      bank_reg, bank_next;
    logic [sfd_pkg::POS_W-1:0] idx;
    logic [sfd_pkg::POS_W-1:0] word;
    logic                      acc;

    // hold the frame end while the other bank still waits to be drained
    assign in_stall = (pos_reg == sfd_pkg::POS_W'(sfd_pkg::POS_TRL2)) && stat.pend;
    assign acc      = in_valid && !in_stall;
    assign idx      = pos_reg - sfd_pkg::POS_W'(sfd_pkg::HDR_LEN);
    assign word     = idx >> 1;

    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        rcrc_next = rcrc_reg;
        lo_next   = lo_reg;
        bank_next = bank_reg;
        wr.we     = 1'b0;
        wr.bank   = bank_reg;
        wr.addr   = sfd_pkg::ram_addr(bank_reg, sfd_pkg::RAM_AW'(word));
        wr.data   = idx[0] ? {rx_byte, lo_reg} : {8'h00, rx_byte};
        done      = '0;
        done.bank = bank_reg;
        done.ok   = (crc_reg == rcrc_reg);
        if (acc)
        begin
            if (pos_reg < sfd_pkg::POS_W'(sfd_pkg::HDR_LEN))
            begin
                if (rx_byte == sfd_pkg::hdr_byte(pos_reg[2:0]))
                begin
                    pos_next = pos_reg + sfd_pkg::POS_W'(1);
                    if (pos_reg == sfd_pkg::POS_W'(sfd_pkg::HDR_LEN - 1))
                    begin
                        crc_next = seed_reg;
                    end
                end
                else
                begin
                    pos_next = sfd_pkg::restart_pos(rx_byte);
                end
            end
            else if (pos_reg < sfd_pkg::POS_W'(sfd_pkg::POS_CRC_LO))
            begin
                crc_next = sfd_pkg::crc_step(crc_reg, rx_byte);
                lo_next  = rx_byte;
                pos_next = pos_reg + sfd_pkg::POS_W'(1);
                // write on the high byte, or on a lone last byte
                if ((idx[0] || idx == sfd_pkg::POS_W'(sfd_pkg::PAYLOAD_BYTES - 1)) &&
                    word < sfd_pkg::POS_W'(sfd_pkg::NUM_WORDS))
                begin
                    wr.we = 1'b1;
                end
            end
            else if (pos_reg == sfd_pkg::POS_W'(sfd_pkg::POS_CRC_LO))
            begin
                rcrc_next = {rcrc_reg[15:8], rx_byte};
                pos_next  = pos_reg + sfd_pkg::POS_W'(1);
            end
            else if (pos_reg == sfd_pkg::POS_W'(sfd_pkg::POS_CRC_HI))
            begin
                rcrc_next = {rx_byte, rcrc_reg[7:0]};
                pos_next  = pos_reg + sfd_pkg::POS_W'(1);
            end
            else if (pos_reg == sfd_pkg::POS_W'(sfd_pkg::POS_TRL0))
            begin
                pos_next = (rx_byte == sfd_pkg::TRL_LT) ? pos_reg + sfd_pkg::POS_W'(1) :
                           sfd_pkg::restart_pos(rx_byte);
            end
            else if (pos_reg == sfd_pkg::POS_W'(sfd_pkg::POS_TRL1))
            begin
                pos_next = (rx_byte == sfd_pkg::TRL_HSH) ? pos_reg + sfd_pkg::POS_W'(1) :
                           sfd_pkg::restart_pos(rx_byte);
            end
            else if (pos_reg == sfd_pkg::POS_W'(sfd_pkg::POS_TRL2) &&
                     rx_byte == sfd_pkg::TRL_LT)
            begin
                done.valid = 1'b1;
                pos_next   = '0;
                bank_next  = !bank_reg;
            end
            else
            begin
                pos_next = sfd_pkg::restart_pos(rx_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            crc_reg  <= '0;
            rcrc_reg <= '0;
            seed_reg <= sfd_pkg::CRC_SEED_RST;
            bank_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            rcrc_reg <= rcrc_next;
            bank_reg <= bank_next;
            if (cfg_wen)
            begin
                seed_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
    end

endmodule

>>> sv/sfd_drain.sv
module sfd_drain (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sfd_pkg::sfd_done_t         done,
    output sfd_pkg::sfd_stat_t         stat,
    output logic [sfd_pkg::RAM_AW-1:0] raddr,
    input  logic [15:0]                rdata,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [15:0]                words [sfd_pkg::NUM_WORDS],
    output logic                       crc_ok
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic                       pend_reg, pend_next;
    logic                       pbank_reg;
    logic                       pok_reg;
    logic [sfd_pkg::WORD_W-1:0] cnt_reg, cnt_next;
    logic                       ret_vld_reg, ret_vld_next;
    logic [sfd_pkg::WORD_W-1:0] ret_idx_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       ok_reg;
    logic [15:0]                word_reg [sfd_pkg::NUM_WORDS];
    logic [15:0]                cap;

    assign stat.pend = pend_reg;
    assign stat.bank = pbank_reg;
    assign raddr     = sfd_pkg::ram_addr(pbank_reg, sfd_pkg::RAM_AW'(cnt_reg));
    assign cap       = (pok_reg && ret_idx_reg < sfd_pkg::WORD_W'(sfd_pkg::STORED_WORDS)) ?
                       rdata : 16'h0000;

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg || done.valid;
        cnt_next       = cnt_reg;
        ret_vld_next   = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (pend_reg && !out_valid_reg)
                begin
                    state_next = S_READ;
                    cnt_next   = '0;
                end
            end
            S_READ:
            begin
                ret_vld_next = 1'b1;
                cnt_next     = cnt_reg + sfd_pkg::WORD_W'(1);
                if (cnt_reg == sfd_pkg::WORD_W'(sfd_pkg::NUM_WORDS - 1))
                begin
                    state_next = S_WAIT;
                    cnt_next   = '0;
                end
            end
            S_WAIT:
            begin
                // last word lands this cycle
                state_next     = S_IDLE;
                pend_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            pbank_reg     <= 1'b0;
            pok_reg       <= 1'b0;
            cnt_reg       <= '0;
            ret_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            ret_vld_reg   <= ret_vld_next;
            out_valid_reg <= out_valid_next;
            if (done.valid)
            begin
                pbank_reg <= done.bank;
                pok_reg   <= done.ok;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ret_idx_reg <= cnt_reg;
        if (ret_vld_reg)
        begin
            word_reg[ret_idx_reg] <= cap;
        end
        if (state_reg == S_WAIT)
        begin
            ok_reg <= pok_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign words     = word_reg;
    assign crc_ok    = ok_reg;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        done.valid |-> !pend_reg)
        else $error("frame completed while previous frame still pending");

    a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (pend_reg && !out_valid_reg))
        else $error("drain running without pending frame or with output busy");

    a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WAIT))
        else $error("output beat raised outside drain completion");
`endif

endmodule
